/* src/control_change_coalescer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Control change coalescer assertion macros
// Shared concurrent assertion forms, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CONTROL_CHANGE_COALESCER_UNIT_ASSERT_SVH
`define CONTROL_CHANGE_COALESCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CCCU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CCCU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CCCU_ASSERT(name, prop, msg)
`define CCCU_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

/* src/ccc_pkg.sv */
// ----------------------------------------------------------------------------
// Control change coalescer package
// Widths, command codes and register indexes.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int SLOTS_DEF  = 64;
  localparam int CTL_W      = 7;
  localparam int CH_W       = 4;
  localparam int KEY_W      = CTL_W + CH_W;
  localparam int VAL_W      = 7;
  localparam int CMD_W      = 2;
  localparam int INTERVAL_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COALESCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd16;

endpackage

/* src/ccc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ccc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/control_change_coalescer_unit.sv */
// ----------------------------------------------------------------------------
// Control change coalescer
// Keyed table of control values with dirty tracking and ordered flushes.
// ----------------------------------------------------------------------------
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------
// command  | start, busy               | cmd, controller, channel, cc_value
// result   | strobe (one cycle)        | out_controller, out_channel,
//          |                           | out_value, last
// config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// An event scans the table through the key RAM, one slot a cycle. A tick
// without a flush only advances the elapsed count. A flush runs one
// minimum-key pass per dirty entry (one pass if none is dirty). Reset
// clears valid and dirty bits at once; no sweep. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "control_change_coalescer_unit_assert.svh"

module control_change_coalescer_unit import ccc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [CTL_W-1:0]      controller,
  input  logic [CH_W-1:0]       channel,
  input  logic [VAL_W-1:0]      cc_value,
  output logic                  strobe,
  output logic [CTL_W-1:0]      out_controller,
  output logic [CH_W-1:0]       out_channel,
  output logic [VAL_W-1:0]      out_value,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam int ENT_W = KEY_W + VAL_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EV_SCAN,
    S_FL_SCAN,
    S_FL_EMIT
  } state_t;

  state_t state;

  logic                  enable;
  logic                  coalesce_identical;
  logic [INTERVAL_W-1:0] ui_interval_ms;
  logic [INTERVAL_W-1:0] elapsed_ms;

  logic [SLOTS-1:0] slot_valid;
  logic [SLOTS-1:0] slot_dirty;

  logic [KEY_W-1:0] ev_key;
  logic [VAL_W-1:0] ev_value;

  logic             issue;
  logic [IDX_W-1:0] scan_idx;
  logic             chk;
  logic [IDX_W-1:0] chk_idx;

  logic             have_free;
  logic [IDX_W-1:0] free_idx;

  logic             have_best;
  logic [IDX_W-1:0] best_idx;
  logic [KEY_W-1:0] best_key;
  logic [VAL_W-1:0] best_value;
  logic [1:0]       cnt;

  logic [ENT_W-1:0] rdata;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic             chk_valid;
  logic             chk_dirty;
  logic             ev_hit;
  logic             ev_end;
  logic             can_place;
  logic [IDX_W-1:0] place_idx;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             fl_take;
  logic             fl_better;
  logic             accept;
  logic [INTERVAL_W:0] tick_count;

  ccc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({ev_key, ev_value}),
    .raddr (scan_idx),
    .rdata (rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign rd_key    = rdata[ENT_W-1:VAL_W];
  assign rd_val    = rdata[VAL_W-1:0];
  assign chk_valid = slot_valid[chk_idx];
  assign chk_dirty = slot_dirty[chk_idx];
  assign tick_count = {1'b0, elapsed_ms} + {{INTERVAL_W{1'b0}}, 1'b1};

  always_comb begin
    ev_hit    = (state == S_EV_SCAN) && chk && chk_valid && (rd_key == ev_key);
    ev_end    = (state == S_EV_SCAN) && chk && !ev_hit && (chk_idx == LAST_IDX);
    can_place = have_free || !chk_valid;
    place_idx = have_free ? free_idx : chk_idx;
    ram_we    = (ev_hit && !(coalesce_identical && (rd_val == ev_value))) ||
                (ev_end && can_place);
    ram_waddr = ev_hit ? chk_idx : place_idx;
    fl_take   = (state == S_FL_SCAN) && chk && chk_valid && chk_dirty;
    fl_better = !have_best || (rd_key < best_key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      enable             <= 1'b0;
      coalesce_identical <= 1'b1;
      ui_interval_ms     <= INTERVAL_RST;
      elapsed_ms         <= '0;
      slot_valid         <= '0;
      slot_dirty         <= '0;
      issue              <= 1'b0;
      chk                <= 1'b0;
      strobe             <= 1'b0;
      have_free          <= 1'b0;
      have_best          <= 1'b0;
      cnt                <= '0;
    end else begin
      strobe <= 1'b0;
      chk    <= issue;
      if (issue) begin
        chk_idx <= scan_idx;
        if (scan_idx == LAST_IDX) begin
          issue <= 1'b0;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE:   enable             <= cfg_data[0];
          REG_COALESCE: coalesce_identical <= cfg_data[0];
          REG_INTERVAL: ui_interval_ms     <= cfg_data[INTERVAL_W-1:0];
          default: ;
        endcase
      end

      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
        slot_dirty[ram_waddr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (accept && enable) begin
            ev_key    <= {controller, channel};
            ev_value  <= cc_value;
            have_free <= 1'b0;
            have_best <= 1'b0;
            cnt       <= '0;
            scan_idx  <= '0;
            chk       <= 1'b0;
            case (cmd)
              CMD_EVENT: begin
                issue <= 1'b1;
                state <= S_EV_SCAN;
              end
              CMD_TICK: begin
                if (tick_count >= {1'b0, ui_interval_ms}) begin
                  elapsed_ms <= '0;
                  issue      <= 1'b1;
                  state      <= S_FL_SCAN;
                end else begin
                  elapsed_ms <= tick_count[INTERVAL_W-1:0];
                end
              end
              CMD_FLUSH: begin
                issue <= 1'b1;
                state <= S_FL_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_EV_SCAN: begin
          if (chk && !chk_valid && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= chk_idx;
          end
          if (ev_hit || ev_end) begin
            issue <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_FL_SCAN: begin
          if (fl_take) begin
            if (cnt != 2'd2) begin
              cnt <= cnt + 2'd1;
            end
            if (fl_better) begin
              have_best  <= 1'b1;
              best_idx   <= chk_idx;
              best_key   <= rd_key;
              best_value <= rd_val;
            end
          end
          if (chk && (chk_idx == LAST_IDX)) begin
            state <= S_FL_EMIT;
          end
        end
        S_FL_EMIT: begin
          if (cnt == 2'd0) begin
            state <= S_IDLE;
          end else begin
            strobe               <= 1'b1;
            out_controller       <= best_key[KEY_W-1:CH_W];
            out_channel          <= best_key[CH_W-1:0];
            out_value            <= best_value;
            last                 <= (cnt == 2'd1);
            slot_dirty[best_idx] <= 1'b0;
            have_best            <= 1'b0;
            cnt                  <= '0;
            if (cnt == 2'd1) begin
              state <= S_IDLE;
            end else begin
              scan_idx <= '0;
              issue    <= 1'b1;
              state    <= S_FL_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CCCU_ASSERT(a_strobe_after_emit, strobe |-> $past(state == S_FL_EMIT), "strobe without emit")
  `CCCU_ASSERT_NEXT(a_strobe_single, strobe, !strobe, "results back to back")
  `CCCU_ASSERT(a_emitted_clean, strobe |-> !slot_dirty[best_idx], "emitted entry still dirty")
  `CCCU_ASSERT(a_last_idle, strobe && last |-> !busy, "busy on last result")

endmodule
